[src/slir_pkg.sv]
// package with shared types and codes for the sorted list block
`timescale 1ns / 1ps

package slir_pkg;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LIST   = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_INSERTED     = 3'd0,
        ST_FULL         = 3'd1,
        ST_REMOVED      = 3'd2,
        ST_NOT_FOUND    = 3'd3,
        ST_EMPTY_REMOVE = 3'd4,
        ST_ENTRY        = 3'd5,
        ST_LIST_EMPTY   = 3'd6
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE,
        S_LIST,
        S_RESP
    } state_t;

    // input transaction payload
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_value;
        logic               last;
    } out_item_t;

endpackage

[src/slir_store.sv]
// single port write, single port read memory with registered read data
`timescale 1ns / 1ps

module slir_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic signed [31:0]  wdata,
    input  logic [AW-1:0]       raddr,
    output logic signed [31:0]  rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/sorted_list_insert_remove.sv]
// top level: sorted list controller with insert, remove and in-order listing
// results: full, remove-on-empty and list-empty give a single status result with no store access;
//   insert moves entries up from the top, remove walks the whole list, and a list streams one
//   entry per cycle unless the output stalls; the next command is taken only in idle, once the
//   current one has loaded its last result
// reset: aresetn clears the entry count and control state; store contents stay undefined
`timescale 1ns / 1ps

module sorted_list_insert_remove #(
    parameter int CAPACITY = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  slir_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output slir_pkg::out_item_t m_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    slir_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic                found_reg, found_next;
    logic signed [31:0]  val_reg, val_next;
    logic [2:0]          resp_reg, resp_next;
    logic                m_valid_reg, m_valid_next;
    slir_pkg::out_item_t m_data_reg, m_data_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic signed [31:0]  mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic signed [31:0]  mem_rdata;

    logic                slot_free;
    logic                out_load;
    logic                ins_done;
    logic                list_last;

    // entry store
    slir_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == slir_pkg::S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign list_last = (CW'(pend_idx_reg) == count_reg - CW'(1));

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= slir_pkg::S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        val_reg      <= val_next;
        resp_reg     <= resp_next;
        m_data_reg   <= m_data_next;
    end

    // next state, memory accesses and result loading
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        val_next        = val_reg;
        resp_next       = resp_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = val_reg;
        mem_raddr       = idx_reg[AW-1:0];
        out_load        = 1'b0;
        ins_done        = 1'b0;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            slir_pkg::S_IDLE: begin
                if (s_valid) begin
                    val_next   = s_data.value;
                    found_next = 1'b0;
                    unique case (s_data.cmd)
                        slir_pkg::CMD_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                resp_next  = slir_pkg::ST_FULL;
                                state_next = slir_pkg::S_RESP;
                            end else begin
                                idx_next   = count_reg;
                                state_next = slir_pkg::S_INSERT;
                            end
                        end
                        slir_pkg::CMD_REMOVE: begin
                            if (count_reg == '0) begin
                                resp_next  = slir_pkg::ST_EMPTY_REMOVE;
                                state_next = slir_pkg::S_RESP;
                            end else begin
                                idx_next   = '0;
                                state_next = slir_pkg::S_REMOVE;
                            end
                        end
                        slir_pkg::CMD_LIST: begin
                            if (count_reg == '0) begin
                                resp_next  = slir_pkg::ST_LIST_EMPTY;
                                state_next = slir_pkg::S_RESP;
                            end else begin
                                idx_next   = '0;
                                state_next = slir_pkg::S_LIST;
                            end
                        end
                        default: begin
                            state_next = slir_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // walk down from the top, moving entries not below the value up by one
            slir_pkg::S_INSERT: begin
                mem_raddr = AW'(idx_reg - CW'(1));
                if (pend_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_idx_reg + AW'(1);
                    if (mem_rdata >= val_reg) begin
                        mem_wdata = mem_rdata;
                    end else begin
                        mem_wdata = val_reg;
                        ins_done  = 1'b1;
                    end
                end else if (idx_reg == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = val_reg;
                    ins_done  = 1'b1;
                end
                if (ins_done) begin
                    count_next = count_reg + CW'(1);
                    resp_next  = slir_pkg::ST_INSERTED;
                    state_next = slir_pkg::S_RESP;
                end else if (idx_reg != '0) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = AW'(idx_reg - CW'(1));
                    idx_next        = idx_reg - CW'(1);
                end
            end

            // walk up, find the first match and move every later entry down by one
            slir_pkg::S_REMOVE: begin
                if (pend_valid_reg) begin
                    if (found_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_idx_reg - AW'(1);
                        mem_wdata = mem_rdata;
                    end else if (mem_rdata == val_reg) begin
                        found_next = 1'b1;
                    end
                end
                if (idx_reg != count_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg[AW-1:0];
                    idx_next        = idx_reg + CW'(1);
                end else if (!pend_valid_reg) begin
                    if (found_reg) begin
                        count_next = count_reg - CW'(1);
                        resp_next  = slir_pkg::ST_REMOVED;
                    end else begin
                        resp_next  = slir_pkg::ST_NOT_FOUND;
                    end
                    state_next = slir_pkg::S_RESP;
                end
            end

            // stream entries out; a stalled entry is simply read again
            slir_pkg::S_LIST: begin
                if (pend_valid_reg && slot_free) begin
                    out_load                = 1'b1;
                    m_data_next.status      = slir_pkg::ST_ENTRY;
                    m_data_next.entry_value = mem_rdata;
                    m_data_next.last        = list_last;
                    if (list_last) begin
                        state_next = slir_pkg::S_IDLE;
                    end
                end
                if (pend_valid_reg && !slot_free) begin
                    mem_raddr       = pend_idx_reg;
                    pend_valid_next = 1'b1;
                end else if (idx_reg != count_reg && !(out_load && list_last)) begin
                    mem_raddr       = idx_reg[AW-1:0];
                    pend_valid_next = 1'b1;
                    pend_idx_next   = idx_reg[AW-1:0];
                    idx_next        = idx_reg + CW'(1);
                end
            end

            // single status result
            slir_pkg::S_RESP: begin
                if (slot_free) begin
                    out_load                = 1'b1;
                    m_data_next.status      = resp_reg;
                    m_data_next.entry_value = '0;
                    m_data_next.last        = 1'b1;
                    state_next              = slir_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = slir_pkg::S_IDLE;
            end
        endcase

        // output register
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // the count never passes the capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a completed insert grows the list by exactly one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_done |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list by one");

    // listing only runs on a non-empty list
    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slir_pkg::S_LIST) |-> count_reg != '0)
        else $error("listing an empty list");

    // writes only land inside the occupied region plus one
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> CW'(mem_waddr) <= count_reg)
        else $error("store write beyond the list");

    // no new transaction is taken while a command is in progress
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slir_pkg::S_INSERT || state_reg == slir_pkg::S_REMOVE ||
         state_reg == slir_pkg::S_LIST) |-> !s_ready)
        else $error("input accepted during a command");

endmodule
